// ===== design/ssl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_pkg
// Shared types and constants of the byte-serial source lexer.
// ----------------------------------------------------------------------------
package ssl_pkg;

  localparam int LINE_BITS_DEF = 16;
  localparam int LINE_OUT_W    = 16;
  localparam int RUN_MAX       = 4;
  localparam int RUN_IDX_W     = $clog2(RUN_MAX);
  localparam int RUN_CNT_W     = $clog2(RUN_MAX + 1);
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  // Characters the classifier looks for
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2,
    KIND_EOT  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CLS_INT = 2'd0,
    CLS_OP  = 2'd1,
    CLS_STR = 2'd2,
    CLS_ID  = 2'd3
  } class_e;

  typedef enum logic [2:0] {
    OPEN_NONE = 3'd0,
    OPEN_INT  = 3'd1,
    OPEN_STR  = 3'd2,
    OPEN_ID   = 3'd3,
    OPEN_ESC  = 3'd4
  } open_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [1:0]            token_class;
    logic [7:0]            out_byte;
    logic [LINE_OUT_W-1:0] line_number;
    logic                  final_of_run;
  } out_t;

  // One result as produced by the front end
  typedef struct packed {
    kind_e                 kind;
    class_e                cls;
    logic [7:0]            chr;
    logic [LINE_OUT_W-1:0] line;
  } res_t;

  // All results caused by one input byte
  typedef struct packed {
    res_t [RUN_MAX-1:0]   res;
    logic [RUN_IDX_W-1:0] last_idx;
  } run_t;

endpackage

// ===== design/simple_source_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simple_source_lexer
// Byte-serial lexer: sorts source text into integer, operator, string and
// identifier tokens and streams token text, token ends, errors and end marks.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------
//  in      | input     | in_valid_i / in_ready_o   | in_i  (ssl_pkg::in_t)
//  out     | output    | out_valid_o / out_ready_i | out_o (ssl_pkg::out_t)
//
// The front end takes one byte per cycle whenever the run queue has room and
// builds in that same cycle the full run of up to four results the byte
// causes. The back end sends one result per cycle when the output is ready,
// so a byte's results leave in turn; they appear in the cycle after their
// byte at the earliest. Bytes that cause no result never enter the queue.
// The queue holds four runs, so input and output stall independently.
// Reset is asynchronous and active low: no open token, line 1, queue empty.
// ----------------------------------------------------------------------------
module simple_source_lexer #(
  parameter int LINE_BITS = ssl_pkg::LINE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ssl_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ssl_pkg::out_t out_o
);

  logic          accept;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  ssl_pkg::run_t push_run;
  ssl_pkg::run_t head_run;

  // Accept a byte whenever a free queue slot is there for its run
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the byte, advance the token state and the line count
  ssl_front #(
    .LINE_BITS (LINE_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_i),
    .push_o   (push),
    .run_o    (push_run)
  );

  // Hold finished runs until the output side takes them
  ssl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_run_i (push_run),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head_run)
  );

  // Drain the head run one transaction at a time
  ssl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head_run),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// ===== design/ssl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_front
// Classifies each byte, updates the open token and line count, and builds the
// run of results that the byte causes.
// ----------------------------------------------------------------------------
module ssl_front #(
  parameter int LINE_BITS = ssl_pkg::LINE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  ssl_pkg::in_t       item_i,
  output logic               push_o,
  output ssl_pkg::run_t      run_o
);

  ssl_pkg::open_e        open_q, open_d;
  logic [LINE_BITS-1:0]  line_q, line_d;

  function automatic ssl_pkg::class_e class_of(ssl_pkg::open_e st);
    ssl_pkg::class_e c;
    unique case (st)
      ssl_pkg::OPEN_INT: c = ssl_pkg::CLS_INT;
      ssl_pkg::OPEN_STR: c = ssl_pkg::CLS_STR;
      ssl_pkg::OPEN_ESC: c = ssl_pkg::CLS_STR;
      default:           c = ssl_pkg::CLS_ID;
    endcase
    return c;
  endfunction

  function automatic ssl_pkg::res_t mk(ssl_pkg::kind_e k, ssl_pkg::class_e c,
                                       logic [7:0] ch, logic [LINE_BITS-1:0] ln);
    ssl_pkg::res_t r;
    r.kind = k;
    r.cls  = c;
    r.chr  = ch;
    r.line = ssl_pkg::LINE_OUT_W'(ln);
    return r;
  endfunction

  always_comb begin
    logic [7:0]                       c;
    logic                             is_digit, is_op, is_ws, is_nl, is_esc_ok;
    ssl_pkg::res_t [ssl_pkg::RUN_MAX-1:0] res;
    logic [ssl_pkg::RUN_CNT_W-1:0]    n;
    ssl_pkg::open_e                   st;
    logic [LINE_BITS-1:0]             ln;

    c  = item_i.text_byte;
    st = open_q;
    ln = line_q;
    res = '0;
    n  = '0;

    is_digit  = (c >= ssl_pkg::CH_0) && (c <= ssl_pkg::CH_9);
    is_op     = (c == ssl_pkg::CH_LBRACE) || (c == ssl_pkg::CH_RBRACE) ||
                (c == ssl_pkg::CH_LPAREN) || (c == ssl_pkg::CH_RPAREN) ||
                (c == ssl_pkg::CH_LBRACK) || (c == ssl_pkg::CH_RBRACK) ||
                (c == ssl_pkg::CH_EQUAL)  || (c == ssl_pkg::CH_SEMI);
    is_ws     = (c == ssl_pkg::CH_SPACE) || (c == ssl_pkg::CH_TAB);
    is_nl     = (c == ssl_pkg::CH_CR) || (c == ssl_pkg::CH_LF);
    is_esc_ok = (c == ssl_pkg::CH_N) || (c == ssl_pkg::CH_R) ||
                (c == ssl_pkg::CH_T) || (c == ssl_pkg::CH_BSLASH);

    if (st == ssl_pkg::OPEN_ESC) begin
      if (is_esc_ok) begin
        st = ssl_pkg::OPEN_STR;
        res[n[ssl_pkg::RUN_IDX_W-1:0]] =
          mk(ssl_pkg::KIND_CHAR, ssl_pkg::CLS_STR, ssl_pkg::CH_BSLASH, ln);
        n = n + 1'b1;
        res[n[ssl_pkg::RUN_IDX_W-1:0]] = mk(ssl_pkg::KIND_CHAR, ssl_pkg::CLS_STR, c, ln);
        n = n + 1'b1;
      end else begin
        // drop the open string
        res[n[ssl_pkg::RUN_IDX_W-1:0]] = mk(ssl_pkg::KIND_ERR, ssl_pkg::CLS_STR, 8'h00, ln);
        n  = n + 1'b1;
        st = ssl_pkg::OPEN_NONE;
      end
    end else if (is_digit) begin
      if (st == ssl_pkg::OPEN_NONE) st = ssl_pkg::OPEN_INT;
      res[n[ssl_pkg::RUN_IDX_W-1:0]] = mk(ssl_pkg::KIND_CHAR, class_of(st), c, ln);
      n = n + 1'b1;
    end else if (is_op || (c == ssl_pkg::CH_BSLASH && st != ssl_pkg::OPEN_STR)) begin
      if (st == ssl_pkg::OPEN_STR && is_op) begin
        res[n[ssl_pkg::RUN_IDX_W-1:0]] = mk(ssl_pkg::KIND_CHAR, ssl_pkg::CLS_STR, c, ln);
        n = n + 1'b1;
      end else begin
        // close the open token, then a one-character operator token
        if (st != ssl_pkg::OPEN_NONE) begin
          res[n[ssl_pkg::RUN_IDX_W-1:0]] = mk(ssl_pkg::KIND_END, class_of(st), 8'h00, ln);
          n = n + 1'b1;
        end
        st = ssl_pkg::OPEN_NONE;
        res[n[ssl_pkg::RUN_IDX_W-1:0]] = mk(ssl_pkg::KIND_CHAR, ssl_pkg::CLS_OP, c, ln);
        n = n + 1'b1;
        res[n[ssl_pkg::RUN_IDX_W-1:0]] = mk(ssl_pkg::KIND_END, ssl_pkg::CLS_OP, 8'h00, ln);
        n = n + 1'b1;
      end
    end else if (c == ssl_pkg::CH_BSLASH) begin
      st = ssl_pkg::OPEN_ESC;
    end else if (is_ws && st == ssl_pkg::OPEN_STR) begin
      res[n[ssl_pkg::RUN_IDX_W-1:0]] = mk(ssl_pkg::KIND_CHAR, ssl_pkg::CLS_STR, c, ln);
      n = n + 1'b1;
    end else if (is_ws || is_nl || c == ssl_pkg::CH_QUOTE) begin
      if (st != ssl_pkg::OPEN_NONE) begin
        res[n[ssl_pkg::RUN_IDX_W-1:0]] = mk(ssl_pkg::KIND_END, class_of(st), 8'h00, ln);
        n = n + 1'b1;
      end
      // a quote opens a string unless it closes one
      if (c == ssl_pkg::CH_QUOTE && st != ssl_pkg::OPEN_STR) begin
        st = ssl_pkg::OPEN_STR;
      end else begin
        st = ssl_pkg::OPEN_NONE;
      end
      if (is_nl && ln != {LINE_BITS{1'b1}}) ln = ln + 1'b1;
    end else begin
      if (st == ssl_pkg::OPEN_NONE || st == ssl_pkg::OPEN_INT) begin
        if (st != ssl_pkg::OPEN_NONE) begin
          res[n[ssl_pkg::RUN_IDX_W-1:0]] = mk(ssl_pkg::KIND_END, class_of(st), 8'h00, ln);
          n = n + 1'b1;
        end
        st = ssl_pkg::OPEN_ID;
      end
      res[n[ssl_pkg::RUN_IDX_W-1:0]] = mk(ssl_pkg::KIND_CHAR, class_of(st), c, ln);
      n = n + 1'b1;
    end

    if (item_i.end_of_text) begin
      if (st != ssl_pkg::OPEN_NONE) begin
        res[n[ssl_pkg::RUN_IDX_W-1:0]] = mk(ssl_pkg::KIND_END, class_of(st), 8'h00, ln);
        n = n + 1'b1;
      end
      st = ssl_pkg::OPEN_NONE;
      res[n[ssl_pkg::RUN_IDX_W-1:0]] = mk(ssl_pkg::KIND_EOT, ssl_pkg::CLS_INT, 8'h00, ln);
      n  = n + 1'b1;
      ln = LINE_BITS'(1);
    end

    open_d       = st;
    line_d       = ln;
    run_o.res    = res;
    run_o.last_idx = ssl_pkg::RUN_IDX_W'(n - 1'b1);
    push_o       = accept_i && (n != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= ssl_pkg::OPEN_NONE;
      line_q <= LINE_BITS'(1);
    end else if (accept_i) begin
      open_q <= open_d;
      line_q <= line_d;
    end
  end

endmodule

// ===== design/ssl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_queue
// Short queue of result runs between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module ssl_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ssl_pkg::run_t push_run_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ssl_pkg::run_t head_o
);

  ssl_pkg::run_t                     slot_q [ssl_pkg::QUEUE_DEPTH];
  logic [ssl_pkg::QUEUE_PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [ssl_pkg::QUEUE_CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == ssl_pkg::QUEUE_CNT_W'(ssl_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + ssl_pkg::QUEUE_CNT_W'(push_i) - ssl_pkg::QUEUE_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= push_run_i;
  end

endmodule

// ===== design/ssl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_back
// Walks the run at the queue head and hands out one result per transaction.
// ----------------------------------------------------------------------------
module ssl_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  ssl_pkg::run_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ssl_pkg::out_t out_o
);

  logic [ssl_pkg::RUN_IDX_W-1:0] idx_q, idx_d;
  ssl_pkg::res_t                 cur;
  logic                          is_final;

  always_comb begin
    cur         = head_i.res[idx_q];
    is_final    = (idx_q == head_i.last_idx);
    out_valid_o = !empty_i;

    out_o.kind         = cur.kind;
    out_o.token_class  = cur.cls;
    out_o.out_byte     = cur.chr;
    out_o.line_number  = cur.line;
    out_o.final_of_run = is_final;

    pop_o = out_valid_o && out_ready_i && is_final;
    idx_d = idx_q;
    if (out_valid_o && out_ready_i) begin
      idx_d = is_final ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== test/ssl_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_result_checker
// Watches both channels of the source lexer, predicts the token stream from
// every accepted byte and compares each accepted result with the oldest
// prediction.
// ----------------------------------------------------------------------------
module ssl_result_checker
  import ssl_pkg::*;
#(
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);

  open_e                open_st;
  logic [LINE_BITS-1:0] line_cnt;
  out_t                 run_q[$];
  out_t                 expected_q[$];
  int                   fail_cnt;
  int                   check_cnt;

  function automatic class_e open_class(open_e st);
    case (st)
      OPEN_INT:           return CLS_INT;
      OPEN_STR, OPEN_ESC: return CLS_STR;
      default:            return CLS_ID;
    endcase
  endfunction

  function automatic bit is_operator(logic [7:0] c);
    return c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAREN || c == CH_RPAREN ||
           c == CH_LBRACK || c == CH_RBRACK || c == CH_EQUAL || c == CH_SEMI;
  endfunction

  function automatic void add_result(kind_e k, class_e c, logic [7:0] b);
    out_t r;
    if (run_q.size() < RUN_MAX) begin
      r.kind         = k;
      r.token_class  = c;
      r.out_byte     = b;
      r.line_number  = LINE_OUT_W'(line_cnt);
      r.final_of_run = 1'b0;
      run_q = {run_q, r};
    end
  endfunction

  function automatic void close_token();
    if (open_st != OPEN_NONE) add_result(KIND_END, open_class(open_st), 8'h00);
    open_st = OPEN_NONE;
  endfunction

  // Operators are one-character tokens of their own
  function automatic void lone_operator(logic [7:0] c);
    close_token();
    add_result(KIND_CHAR, CLS_OP, c);
    add_result(KIND_END, CLS_OP, 8'h00);
  endfunction

  function automatic void lex_byte(in_t tx);
    logic [7:0] c;
    c = tx.text_byte;
    run_q.delete();
    if (open_st == OPEN_ESC) begin
      if (c == CH_N || c == CH_R || c == CH_T || c == CH_BSLASH) begin
        open_st = OPEN_STR;
        add_result(KIND_CHAR, CLS_STR, CH_BSLASH);
        add_result(KIND_CHAR, CLS_STR, c);
      end else begin
        // unknown escape: report and drop the string, no token end
        add_result(KIND_ERR, CLS_STR, 8'h00);
        open_st = OPEN_NONE;
      end
    end else if (c >= CH_0 && c <= CH_9) begin
      if (open_st == OPEN_NONE) open_st = OPEN_INT;
      add_result(KIND_CHAR, open_class(open_st), c);
    end else if (is_operator(c)) begin
      if (open_st == OPEN_STR) add_result(KIND_CHAR, CLS_STR, c);
      else lone_operator(c);
    end else if (c == CH_SPACE || c == CH_TAB) begin
      if (open_st == OPEN_STR) add_result(KIND_CHAR, CLS_STR, c);
      else close_token();
    end else if (c == CH_CR || c == CH_LF) begin
      close_token();
      if (line_cnt != '1) line_cnt = line_cnt + 1'b1;
    end else if (c == CH_QUOTE) begin
      if (open_st != OPEN_STR) begin
        close_token();
        open_st = OPEN_STR;
      end else begin
        close_token();
      end
    end else if (c == CH_BSLASH) begin
      if (open_st == OPEN_STR) open_st = OPEN_ESC;
      else lone_operator(c);
    end else begin
      if (open_st == OPEN_NONE || open_st == OPEN_INT) begin
        close_token();
        open_st = OPEN_ID;
      end
      add_result(KIND_CHAR, open_class(open_st), c);
    end

    if (tx.end_of_text) begin
      close_token();
      add_result(KIND_EOT, CLS_INT, 8'h00);
      line_cnt = LINE_BITS'(1);
    end

    if (run_q.size() != 0) begin
      run_q[run_q.size() - 1].final_of_run = 1'b1;
      foreach (run_q[i]) expected_q = {expected_q, run_q[i]};
    end
  endfunction

  function automatic void check_result(out_t got);
    out_t want;
    check_cnt++;
    if (expected_q.size() == 0) begin
      if (fail_cnt < 10)
        $display("%0t: unexpected result kind=%0d class=%0d byte=%02h line=%0d last=%0d",
                 $time, got.kind, got.token_class, got.out_byte, got.line_number,
                 got.final_of_run);
      fail_cnt++;
    end else begin
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.token_class !== want.token_class ||
          got.out_byte !== want.out_byte || got.line_number !== want.line_number ||
          got.final_of_run !== want.final_of_run) begin
        if (fail_cnt < 10) begin
          $display("%0t: result %0d wrong", $time, check_cnt);
          $display("  expected kind=%0d class=%0d byte=%02h line=%0d last=%0d",
                   want.kind, want.token_class, want.out_byte, want.line_number,
                   want.final_of_run);
          $display("  actual   kind=%0d class=%0d byte=%02h line=%0d last=%0d",
                   got.kind, got.token_class, got.out_byte, got.line_number,
                   got.final_of_run);
        end
        fail_cnt++;
      end
    end
  endfunction

  // Process the input side first so a same-edge result sees its prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_st = OPEN_NONE;
      line_cnt = LINE_BITS'(1);
      expected_q.delete();
      fail_cnt = 0;
      check_cnt = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) lex_byte(in_i);
      if (out_valid_i && out_ready_i) check_result(out_i);
      fail_count_o <= fail_cnt;
      pending_o <= expected_q.size();
      checked_o <= check_cnt;
    end
  end

endmodule

// ===== test/tb_simple_source_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_simple_source_lexer
// Feeds the byte-serial lexer with directed token text and random source
// text, with random gaps on both channels. A checker beside the block
// predicts and compares every result; this module only makes stimulus and
// gives the verdict.
// ----------------------------------------------------------------------------
module tb_simple_source_lexer;
  import ssl_pkg::*;

  localparam int         LINE_BITS   = LINE_BITS_DEF;
  localparam int         IDLE_LIMIT  = 1000;  // cycles with no transaction at all
  localparam int         TAIL_CYCLES = 16;    // settle time after the last result
  localparam logic [7:0] LETTER_A    = 8'h61;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  int fail_count;
  int pending;
  int checked;
  int sent;
  int idle_cycles;
  bit steady;  // when set, neither side inserts gaps

  simple_source_lexer #(
    .LINE_BITS(LINE_BITS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_data)
  );

  ssl_result_checker #(
    .LINE_BITS(LINE_BITS)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_i        (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_i       (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: after each transaction drop ready at random, then raise it and
  // hold it high until the next transaction. Ready never falls and rises in
  // the same step.
  initial begin
    int stall;
    out_ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        stall = steady ? 0 : $urandom_range(0, 3);
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Send one byte: idle a random gap first (none when steady), then hold valid and payload until
  // the transaction. Returns in the step of the accepting edge with valid
  // still high, so back-to-back bytes keep valid up without a glitch.
  task automatic feed_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= '{text_byte: b, end_of_text: eot};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Drop valid and hold off until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Rare end of text, so most text forms longer multi-line runs
  function automatic logic rare_eot();
    return $urandom_range(0, 39) == 0;
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 8))
      0:       return CH_LBRACE;
      1:       return CH_RBRACE;
      2:       return CH_LPAREN;
      3:       return CH_RPAREN;
      4:       return CH_LBRACK;
      5:       return CH_RBRACK;
      6:       return CH_EQUAL;
      7:       return CH_SEMI;
      default: return CH_BSLASH;  // lone backslash outside a string
    endcase
  endfunction

  // Send one random token: mostly well-formed identifiers, integers,
  // operators and strings, with whitespace, line breaks and raw noise bytes.
  task automatic feed_token();
    int         pick;
    int         len;
    logic [7:0] c;
    pick = $urandom_range(0, 19);
    if (pick < 4) begin
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++) begin
        if (i == 0 && $urandom_range(0, 3) == 0) c = 8'h80 + 8'($urandom_range(0, 127));
        else if (i > 0 && $urandom_range(0, 2) == 0) c = CH_0 + 8'($urandom_range(0, 9));
        else c = LETTER_A + 8'($urandom_range(0, 25));
        feed_byte(c, rare_eot());
      end
    end else if (pick < 7) begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) feed_byte(CH_0 + 8'($urandom_range(0, 9)), rare_eot());
    end else if (pick < 10) begin
      feed_byte(pick_operator(), rare_eot());
    end else if (pick < 13) begin
      feed_byte(CH_QUOTE, rare_eot());
      len = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          // escape: mostly legal escape bytes, sometimes an arbitrary byte
          feed_byte(CH_BSLASH, rare_eot());
          case ($urandom_range(0, 5))
            0:       c = 8'($urandom_range(0, 255));
            1:       c = CH_N;
            2:       c = CH_R;
            3:       c = CH_T;
            default: c = CH_BSLASH;
          endcase
        end else begin
          c = 8'($urandom_range(8'h20, 8'h7E));
          if (c == CH_QUOTE || c == CH_BSLASH) c = LETTER_A;
        end
        feed_byte(c, rare_eot());
      end
      // close the string, or break it with a newline now and then
      feed_byte(($urandom_range(0, 7) == 0) ? CH_LF : CH_QUOTE, rare_eot());
    end else if (pick < 15) begin
      feed_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB, rare_eot());
    end else if (pick < 17) begin
      feed_byte($urandom_range(0, 1) ? CH_CR : CH_LF, rare_eot());
    end else begin
      feed_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int mark;
    steady   = 1'b0;
    sent     = 0;
    in_valid <= 1'b0;
    in_data  <= '0;
    rst_n    <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed text: integer turning into identifier, operator, tab
    feed_byte(CH_0 + 8'd1, 1'b0);
    feed_byte(CH_0 + 8'd2, 1'b0);
    feed_byte(LETTER_A, 1'b0);
    feed_byte(CH_LPAREN, 1'b0);
    feed_byte(CH_TAB, 1'b0);
    // string with legal escapes, then a quote after a backslash (bad escape)
    feed_byte(CH_QUOTE, 1'b0);
    feed_byte(CH_BSLASH, 1'b0);
    feed_byte(CH_N, 1'b0);
    feed_byte(CH_BSLASH, 1'b0);
    feed_byte(CH_BSLASH, 1'b0);
    feed_byte(CH_BSLASH, 1'b0);
    feed_byte(CH_QUOTE, 1'b0);
    // empty string
    feed_byte(CH_QUOTE, 1'b0);
    feed_byte(CH_QUOTE, 1'b0);
    // newline inside a string ends it
    feed_byte(CH_QUOTE, 1'b0);
    feed_byte(CH_SPACE, 1'b0);
    feed_byte(CH_LF, 1'b0);
    // byte extremes as identifier text, lone backslash, end of text
    feed_byte(8'hFF, 1'b0);
    feed_byte(8'h00, 1'b0);
    feed_byte(CH_BSLASH, 1'b0);
    feed_byte(CH_SEMI, 1'b1);
    // escape still open when the text ends
    feed_byte(CH_QUOTE, 1'b0);
    feed_byte(CH_BSLASH, 1'b0);
    feed_byte(CH_R, 1'b0);
    feed_byte(CH_BSLASH, 1'b1);
    wait_drained();

    // Random text: idle gaps, a full drain, a gap-free stretch, then gaps again
    mark = sent;
    while (sent < mark + 50) feed_token();
    wait_drained();
    steady = 1'b1;
    mark = sent;
    while (sent < mark + 25) feed_token();
    steady = 1'b0;
    mark = sent;
    while (sent < mark + 25) feed_token();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d bytes: directed tokens and escapes, then random text", sent);
    $display("%0d lexer results compared against the predicted token stream", checked);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
